@@ hw/rtl/vfc_pkg.sv @@
// Package for the view-frustum cull test: plane store geometry, codes and datapath widths.
`timescale 1ns / 1ps
`default_nettype none

package vfc_pkg;

    // Plane store geometry: one row of four coefficients per plane.
    localparam int PLANE_COUNT = 6;
    localparam int PLANE_AW    = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int WORD_W      = 32;
    localparam int PLANE_W     = 4 * WORD_W;

    // Datapath widths: product, distance accumulator and corner sums.
    localparam int PROD_W = 2 * WORD_W;
    localparam int DIST_W = PROD_W + 2;
    localparam int CORN_W = DIST_W + 2;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_POINT  = 2'd1;
    localparam logic [1:0] OP_SPHERE = 2'd2;
    localparam logic [1:0] OP_BOX    = 2'd3;

    // Verdict codes of a result item.
    localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

    typedef logic signed [DIST_W-1:0] t_dist;
    typedef logic signed [CORN_W-1:0] t_corner;

endpackage

`default_nettype wire

@@ hw/rtl/vfc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/view_frustum_cull_test.sv @@
// Top level of the view-frustum cull test: plane store, shared multiplier and test sequencer.
// Load item: written in the accept cycle, no result, busy stays low.
// Point and sphere tests, per plane: fetch, three products, accumulate, evaluate.
// Box test, per plane: fetch, six products, accumulate, pair sums, evaluate.
// The single 32x32 multiplier serialises the products; a test stops at the first deciding plane,
// and the verdict strobe is registered in the cycle after the last evaluation.
// Reset is synchronous and active low; it clears the sequencer and strobe, not the plane store.
`timescale 1ns / 1ps
`default_nettype none

module view_frustum_cull_test (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [2:0]  i_plane_index,
    input  wire logic [31:0] i_plane_a,
    input  wire logic [31:0] i_plane_b,
    input  wire logic [31:0] i_plane_c,
    input  wire logic [31:0] i_plane_d,
    input  wire logic [31:0] i_center_x,
    input  wire logic [31:0] i_center_y,
    input  wire logic [31:0] i_center_z,
    input  wire logic [30:0] i_extent_x,
    input  wire logic [30:0] i_extent_y,
    input  wire logic [30:0] i_extent_z,
    output logic             o_valid,
    output logic [1:0]       o_verdict
);

    import vfc_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_PAIR  = 3'd4;
    localparam logic [2:0] ST_EVAL  = 3'd5;

    // Multiplier steps: three centre products, then three extent products for a box.
    localparam logic [2:0] STEP_AX  = 3'd0;
    localparam logic [2:0] STEP_BY  = 3'd1;
    localparam logic [2:0] STEP_CZ  = 3'd2;
    localparam logic [2:0] STEP_AEX = 3'd3;
    localparam logic [2:0] STEP_BEY = 3'd4;
    localparam logic [2:0] STEP_CEZ = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [2:0]          r_step, n_step;
    logic [PLANE_AW-1:0] r_plane, n_plane;
    logic                r_all_full, n_all_full;
    logic                r_valid, n_valid;
    logic [1:0]          r_verdict, n_verdict;

    logic [1:0]               r_op;
    logic signed [WORD_W-1:0] r_cx, r_cy, r_cz;
    logic [WORD_W-2:0]        r_ex, r_ey, r_ez;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic [2:0]               r_psel;
    t_dist                    r_dist;
    logic signed [PROD_W-1:0] r_ta, r_tb, r_tc;
    t_corner                  r_v0, r_v1, r_u0, r_u1;

    logic [PLANE_W-1:0]       rd_row;
    logic signed [WORD_W-1:0] coef_a, coef_b, coef_c, coef_d;
    logic signed [WORD_W-1:0] m_a, m_b;
    logic                     accept;
    logic                     load_we;
    logic                     last_plane;
    logic                     is_box;
    logic [2:0]               last_step;
    t_dist                    rad, neg_rad;
    t_corner                  corner [8];
    logic [7:0]               pos_vec;
    logic                     none_pos, all_pos;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign load_we   = accept && (i_op == OP_LOAD)
                       && ({1'b0, i_plane_index} < 4'(PLANE_COUNT));
    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

    // Plane store: one row {d, c, b, a} per plane.
    vfc_ram #(
        .WIDTH (PLANE_W),
        .DEPTH (PLANE_COUNT),
        .AW    (PLANE_AW)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_plane_index[PLANE_AW-1:0]),
        .i_wdata ({i_plane_d, i_plane_c, i_plane_b, i_plane_a}),
        .i_raddr (r_plane),
        .o_rdata (rd_row)
    );

    assign coef_a = rd_row[WORD_W-1:0];
    assign coef_b = rd_row[2*WORD_W-1:WORD_W];
    assign coef_c = rd_row[3*WORD_W-1:2*WORD_W];
    assign coef_d = rd_row[4*WORD_W-1:3*WORD_W];

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_step)
            STEP_AX: begin
                m_a = coef_a;
                m_b = r_cx;
            end
            STEP_BY: begin
                m_a = coef_b;
                m_b = r_cy;
            end
            STEP_CZ: begin
                m_a = coef_c;
                m_b = r_cz;
            end
            STEP_AEX: begin
                m_a = coef_a;
                m_b = {1'b0, r_ex};
            end
            STEP_BEY: begin
                m_a = coef_b;
                m_b = {1'b0, r_ey};
            end
            STEP_CEZ: begin
                m_a = coef_c;
                m_b = {1'b0, r_ez};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Sphere radius in the Q34.32 scale of the distance.
    assign rad     = {{(DIST_W-WORD_W-15){1'b0}}, r_ex, 16'b0};
    assign neg_rad = -rad;

    // Eight box corners as (distance +/- x term) +/- (y term +/- z term).
    assign corner[0] = r_v0 + r_u0;
    assign corner[1] = r_v0 - r_u0;
    assign corner[2] = r_v0 + r_u1;
    assign corner[3] = r_v0 - r_u1;
    assign corner[4] = r_v1 + r_u0;
    assign corner[5] = r_v1 - r_u0;
    assign corner[6] = r_v1 + r_u1;
    assign corner[7] = r_v1 - r_u1;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pos_vec[i] = !corner[i][CORN_W-1] && (corner[i] != '0);
        end
    end

    assign none_pos   = ~|pos_vec;
    assign all_pos    = &pos_vec;
    assign last_plane = (r_plane == PLANE_AW'(PLANE_COUNT - 1));
    assign is_box     = (r_op == OP_BOX);
    assign last_step  = is_box ? STEP_CEZ : STEP_CZ;

    // Sequencer: one plane at a time, stopping at the first plane that decides.
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_plane    = r_plane;
        n_all_full = r_all_full;
        n_valid    = 1'b0;
        n_verdict  = r_verdict;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_op != OP_LOAD)) begin
                    n_state    = ST_FETCH;
                    n_plane    = '0;
                    n_step     = STEP_AX;
                    n_all_full = 1'b1;
                end
            end
            ST_FETCH: begin
                n_state = ST_MUL;
                n_step  = STEP_AX;
            end
            ST_MUL: begin
                if (r_step == last_step) begin
                    n_state = ST_LAST;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_LAST: begin
                n_state = is_box ? ST_PAIR : ST_EVAL;
            end
            ST_PAIR: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_FETCH;
                n_plane = r_plane + PLANE_AW'(1);
                case (r_op)
                    OP_POINT: begin
                        if (r_dist[DIST_W-1] || (r_dist == '0)) begin
                            n_state   = ST_IDLE;
                            n_valid   = 1'b1;
                            n_verdict = VERDICT_OUTSIDE;
                        end else if (last_plane) begin
                            n_state   = ST_IDLE;
                            n_valid   = 1'b1;
                            n_verdict = VERDICT_INSIDE;
                        end
                    end
                    OP_SPHERE: begin
                        if (r_dist < neg_rad) begin
                            n_state   = ST_IDLE;
                            n_valid   = 1'b1;
                            n_verdict = VERDICT_OUTSIDE;
                        end else if ((r_dist > neg_rad) && (r_dist < rad)) begin
                            n_state   = ST_IDLE;
                            n_valid   = 1'b1;
                            n_verdict = VERDICT_INTERSECT;
                        end else if (last_plane) begin
                            n_state   = ST_IDLE;
                            n_valid   = 1'b1;
                            n_verdict = VERDICT_INSIDE;
                        end
                    end
                    default: begin
                        n_all_full = r_all_full && all_pos;
                        if (none_pos) begin
                            n_state   = ST_IDLE;
                            n_valid   = 1'b1;
                            n_verdict = VERDICT_OUTSIDE;
                        end else if (last_plane) begin
                            n_state   = ST_IDLE;
                            n_valid   = 1'b1;
                            n_verdict = (r_all_full && all_pos) ? VERDICT_INSIDE
                                                                : VERDICT_INTERSECT;
                        end
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_AX;
            r_plane <= '0;
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_plane <= n_plane;
            r_valid <= n_valid;
            r_pv    <= (r_state == ST_MUL);
        end
    end

    // Item capture, verdict and box flag.
    always_ff @(posedge i_clk) begin
        r_all_full <= n_all_full;
        r_verdict  <= n_verdict;
        if (accept) begin
            r_op <= i_op;
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_cz <= i_center_z;
            r_ex <= i_extent_x;
            r_ey <= i_extent_y;
            r_ez <= i_extent_z;
        end
    end

    // Shared multiplier, registered, and the accumulation in the cycle after each product.
    always_ff @(posedge i_clk) begin
        r_psel <= r_step;
        if (r_state == ST_MUL) begin
            r_prod <= m_a * m_b;
        end
        if ((r_state == ST_MUL) && (r_step == STEP_AX)) begin
            r_dist <= {{(DIST_W-WORD_W-16){coef_d[WORD_W-1]}}, coef_d, 16'b0};
        end else if (r_pv) begin
            case (r_psel)
                STEP_AX, STEP_BY, STEP_CZ: begin
                    r_dist <= r_dist + {{(DIST_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                default: begin
                    r_dist <= r_dist;
                end
            endcase
        end
        if (r_pv && (r_psel == STEP_AEX)) begin
            r_ta <= r_prod;
        end
        if (r_pv && (r_psel == STEP_BEY)) begin
            r_tb <= r_prod;
        end
        if (r_pv && (r_psel == STEP_CEZ)) begin
            r_tc <= r_prod;
        end
        // Pair sums for the corner evaluation.
        if (r_state == ST_PAIR) begin
            r_v0 <= {{(CORN_W-DIST_W){r_dist[DIST_W-1]}}, r_dist}
                    + {{(CORN_W-PROD_W){r_ta[PROD_W-1]}}, r_ta};
            r_v1 <= {{(CORN_W-DIST_W){r_dist[DIST_W-1]}}, r_dist}
                    - {{(CORN_W-PROD_W){r_ta[PROD_W-1]}}, r_ta};
            r_u0 <= {{(CORN_W-PROD_W){r_tb[PROD_W-1]}}, r_tb}
                    + {{(CORN_W-PROD_W){r_tc[PROD_W-1]}}, r_tc};
            r_u1 <= {{(CORN_W-PROD_W){r_tb[PROD_W-1]}}, r_tb}
                    - {{(CORN_W-PROD_W){r_tc[PROD_W-1]}}, r_tc};
        end
    end

endmodule

`default_nettype wire
